// ----- design/assert_macros.svh -----
// assertion helpers shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define PCRP_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
	else $error("parser assertion failed");

// cond on one edge implies nxt on the following edge
`define PCRP_ASSERT_NEXT(lbl, clk_i, rst_ni, cond, nxt) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
	else $error("parser assertion failed");

`endif

// ----- design/pcrp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrp_pkg
// shared types and constants of the point-cloud record parser
// ----------------------------------------------------------------------------
package pcrp_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [1:0] KIND_POINT    = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_MISMATCH = 2'd2;
	localparam logic [1:0] KIND_TRUNC    = 2'd3;

	localparam logic CFG_MAJOR = 1'b0;
	localparam logic CFG_MINOR = 1'b1;

	// result as classified by the front part, colour still packed rgb565
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
		logic [15:0] color;
		logic        file_done;
	} rec_t;

	// result as presented on the output ports
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        file_done;
	} res_t;

endpackage

// ----- design/pcrp_queue.sv -----
// ----------------------------------------------------------------------------
// pcrp_queue
// short register queue between the byte parser and the result stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcrp_queue
	import pcrp_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t wr_rec,
	input  logic rd_en,
	output rec_t rd_rec,
	output logic full,
	output logic empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rec_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_rec = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`PCRP_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_CNT)
	`PCRP_ASSERT_NEXT(a_count_grows, clk, arst_n, do_wr && !do_rd,
		count_q == $past(count_q) + 1'b1)

endmodule

// ----- design/pcrp_front.sv -----
// ----------------------------------------------------------------------------
// pcrp_front
// byte parser: version check, header skip, point count and point records
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcrp_front
	import pcrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        emit,
	output rec_t        rec
);
	localparam logic [3:0] PH_MAJOR   = 4'd0;
	localparam logic [3:0] PH_MINOR   = 4'd1;
	localparam logic [3:0] PH_GROUPS  = 4'd2;
	localparam logic [3:0] PH_PAIRCNT = 4'd3;
	localparam logic [3:0] PH_PAIR    = 4'd4;
	localparam logic [3:0] PH_POINTS  = 4'd5;
	localparam logic [3:0] PH_X       = 4'd6;
	localparam logic [3:0] PH_Y       = 4'd7;
	localparam logic [3:0] PH_Z       = 4'd8;
	localparam logic [3:0] PH_COLOR   = 4'd9;
	localparam logic [3:0] PH_SKIP    = 4'd10;

	logic [15:0] exp_major_q, exp_minor_q;
	logic [3:0]  phase_q, phase_d;
	logic [1:0]  byte_idx_q, byte_idx_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] groups_q, groups_d;
	logic [32:0] pairs_q, pairs_d;
	logic [31:0] points_q, points_d;
	logic [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
	logic [15:0] major_q, major_d;

	logic [15:0] acc16;
	logic [31:0] acc_var;
	logic [31:0] acc_word;
	logic [31:0] groups_dec;
	logic [31:0] points_dec;
	logic        closed;
	logic        emit_pre;
	rec_t        rec_pre;

	assign acc16      = {acc_q[7:0], data_byte};
	assign acc_var    = {acc_q[24:0], data_byte[6:0]};
	assign acc_word   = {acc_q[23:0], data_byte};
	assign groups_dec = groups_q - 32'd1;
	assign points_dec = points_q - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_major_q <= 16'd1;
			exp_minor_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAJOR: exp_major_q <= cfg_data;
				CFG_MINOR: exp_minor_q <= cfg_data;
				default:   exp_major_q <= exp_major_q;
			endcase
		end
	end

	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		acc_d      = acc_q;
		groups_d   = groups_q;
		pairs_d    = pairs_q;
		points_d   = points_q;
		x_d        = x_q;
		y_d        = y_q;
		z_d        = z_q;
		major_d    = major_q;
		closed     = 1'b0;
		emit_pre   = 1'b0;
		rec_pre    = '0;

		case (phase_q)
			PH_MAJOR, PH_MINOR: begin
				if (byte_idx_q == 2'd0) begin
					byte_idx_d = 2'd1;
					acc_d      = {16'd0, acc16};
				end else begin
					byte_idx_d = 2'd0;
					acc_d      = '0;
					if (phase_q == PH_MAJOR) begin
						major_d = acc16;
						phase_d = PH_MINOR;
					end else if (major_q != exp_major_q || acc16 != exp_minor_q) begin
						emit_pre          = 1'b1;
						rec_pre.kind      = KIND_MISMATCH;
						rec_pre.file_done = 1'b1;
						closed            = 1'b1;
						phase_d           = PH_SKIP;
					end else begin
						phase_d = PH_GROUPS;
					end
				end
			end
			PH_GROUPS, PH_PAIRCNT, PH_PAIR, PH_POINTS: begin
				acc_d = acc_var;
				// a set top bit ends the varint
				if (data_byte[7]) begin
					acc_d = '0;
					case (phase_q)
						PH_GROUPS: begin
							groups_d = acc_var;
							phase_d  = (acc_var == '0) ? PH_POINTS : PH_PAIRCNT;
						end
						PH_PAIRCNT: begin
							groups_d = groups_dec;
							pairs_d  = {acc_var, 1'b0};
							if (acc_var == '0) begin
								phase_d = (groups_dec == '0) ? PH_POINTS : PH_PAIRCNT;
							end else begin
								phase_d = PH_PAIR;
							end
						end
						PH_PAIR: begin
							pairs_d = pairs_q - 33'd1;
							if (pairs_q == 33'd1) begin
								phase_d = (groups_q == '0) ? PH_POINTS : PH_PAIRCNT;
							end
						end
						default: begin
							points_d = acc_var;
							if (acc_var == '0) begin
								emit_pre          = 1'b1;
								rec_pre.kind      = KIND_EMPTY;
								rec_pre.file_done = 1'b1;
								closed            = 1'b1;
								phase_d           = PH_SKIP;
							end else begin
								phase_d = PH_X;
							end
						end
					endcase
				end
			end
			PH_X, PH_Y, PH_Z: begin
				if (byte_idx_q != 2'd3) begin
					byte_idx_d = byte_idx_q + 2'd1;
					acc_d      = acc_word;
				end else begin
					byte_idx_d = 2'd0;
					acc_d      = '0;
					case (phase_q)
						PH_X: begin
							x_d     = acc_word;
							phase_d = PH_Y;
						end
						PH_Y: begin
							y_d     = acc_word;
							phase_d = PH_Z;
						end
						default: begin
							z_d     = acc_word;
							phase_d = PH_COLOR;
						end
					endcase
				end
			end
			PH_COLOR: begin
				if (byte_idx_q == 2'd0) begin
					byte_idx_d = 2'd1;
					acc_d      = {16'd0, acc16};
				end else begin
					byte_idx_d        = 2'd0;
					acc_d             = '0;
					points_d          = points_dec;
					emit_pre          = 1'b1;
					rec_pre.kind      = KIND_POINT;
					rec_pre.x_bits    = x_q;
					rec_pre.y_bits    = y_q;
					rec_pre.z_bits    = z_q;
					rec_pre.color     = acc16;
					rec_pre.file_done = (points_dec == '0);
					if (points_dec == '0) begin
						closed  = 1'b1;
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_X;
					end
				end
			end
			default: begin
				// file closed: drop bytes until end of file
				closed  = 1'b1;
				phase_d = PH_SKIP;
			end
		endcase

		if (end_of_file) begin
			if (!closed) begin
				emit_pre          = 1'b1;
				rec_pre           = '0;
				rec_pre.kind      = KIND_TRUNC;
				rec_pre.file_done = 1'b1;
			end
			phase_d    = PH_MAJOR;
			byte_idx_d = 2'd0;
			acc_d      = '0;
			groups_d   = '0;
			pairs_d    = '0;
			points_d   = '0;
			x_d        = '0;
			y_d        = '0;
			z_d        = '0;
			major_d    = '0;
		end
	end

	assign emit = accept && emit_pre;
	assign rec  = rec_pre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAJOR;
			byte_idx_q <= '0;
			acc_q      <= '0;
			groups_q   <= '0;
			pairs_q    <= '0;
			points_q   <= '0;
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= '0;
			major_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			byte_idx_q <= byte_idx_d;
			acc_q      <= acc_d;
			groups_q   <= groups_d;
			pairs_q    <= pairs_d;
			points_q   <= points_d;
			x_q        <= x_d;
			y_q        <= y_d;
			z_q        <= z_d;
			major_q    <= major_d;
		end
	end

	`PCRP_ASSERT(a_eof_restarts, clk, arst_n,
		(accept && end_of_file) |=> (phase_q == PH_MAJOR && byte_idx_q == 2'd0))
	`PCRP_ASSERT(a_status_closes, clk, arst_n,
		(emit && rec.kind != KIND_POINT) |-> rec.file_done)

endmodule

// ----- design/pcrp_back.sv -----
// ----------------------------------------------------------------------------
// pcrp_back
// result stage: colour expansion into the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcrp_back
	import pcrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  rec_t q_rec,
	output logic q_pop,
	input  logic pop,
	output logic res_valid,
	output res_t res
);
	// floor(v/31) for v <= 7905 as (v*Recip31) >> 18, floor(v/63) for v <= 16065
	localparam logic [13:0] Recip31 = 14'd8457;
	localparam logic [14:0] Recip63 = 15'd16645;

	logic        valid_q;
	res_t        res_q;
	logic [12:0] prod_r, prod_b;
	logic [13:0] prod_g;
	logic [26:0] quot_r, quot_b;
	logic [28:0] quot_g;
	res_t        res_d;

	assign q_pop = q_valid && (!valid_q || pop);

	assign prod_r = 13'(q_rec.color[15:11]) * 13'd255;
	assign prod_g = 14'(q_rec.color[10:5]) * 14'd255;
	assign prod_b = 13'(q_rec.color[4:0]) * 13'd255;
	assign quot_r = 27'(prod_r) * 27'(Recip31);
	assign quot_g = 29'(prod_g) * 29'(Recip63);
	assign quot_b = 27'(prod_b) * 27'(Recip31);

	always_comb begin
		res_d.kind      = q_rec.kind;
		res_d.x_bits    = q_rec.x_bits;
		res_d.y_bits    = q_rec.y_bits;
		res_d.z_bits    = q_rec.z_bits;
		res_d.red       = quot_r[25:18];
		res_d.green     = quot_g[27:20];
		res_d.blue      = quot_b[25:18];
		res_d.file_done = q_rec.file_done;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

	`PCRP_ASSERT(a_fill_when_free, clk, arst_n, (q_valid && !valid_q) |=> valid_q)

endmodule

// ----- design/point_cloud_record_parser_core.sv -----
// ----------------------------------------------------------------------------
// point_cloud_record_parser_core
// point-cloud file parser: version check, header skip, point records out
// ----------------------------------------------------------------------------
// Usage
//   input: one file byte per transfer (data_byte, end_of_file), pushed while
//   full is low. The parser takes one byte per cycle; full rises only when
//   the internal result queue is full.
//   results: the oldest result sits on kind .. file_done while empty is low
//   and leaves on pop. kind 0 is a point (raw float bits, 8-bit colour),
//   1 an empty file, 2 a version mismatch, 3 a truncated file.
//   path: a result is written into the queue on the transfer of the byte that
//   causes it, then moves into the colour expansion register once that is
//   free or being popped; a receiver that stalls holds it in the queue.
//   throughput: one byte per cycle, one result per cycle while pop is held,
//   set by the byte parser state update and the single output register.
//   a receiver that stalls lets the queue fill; bytes keep flowing until it
//   is full, then full holds off the sender.
//   cfg_we writes expected_major (index 0) or expected_minor (index 1); write
//   them only while no byte is in flight.
//   reset clears the parser to the start of a file, empties the queue and
//   sets the expected version to 1.0.
// ----------------------------------------------------------------------------
module point_cloud_record_parser_core
	import pcrp_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] x_bits,
	output logic [31:0] y_bits,
	output logic [31:0] z_bits,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        file_done,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	logic accept;
	logic emit;
	rec_t front_rec;
	rec_t q_rec;
	logic q_empty;
	logic q_pop;
	logic res_valid;
	res_t res;

	assign accept = push && !full;

	pcrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.emit       (emit),
		.rec        (front_rec)
	);

	pcrp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (emit),
		.wr_rec(front_rec),
		.rd_en (q_pop),
		.rd_rec(q_rec),
		.full  (full),
		.empty (q_empty)
	);

	pcrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_empty),
		.q_rec    (q_rec),
		.q_pop    (q_pop),
		.pop      (pop),
		.res_valid(res_valid),
		.res      (res)
	);

	assign empty     = !res_valid;
	assign kind      = res.kind;
	assign x_bits    = res.x_bits;
	assign y_bits    = res.y_bits;
	assign z_bits    = res.z_bits;
	assign red       = res.red;
	assign green     = res.green;
	assign blue      = res.blue;
	assign file_done = res.file_done;

endmodule
